// ===== rtl/picsr_pkg.sv =====
// ----------------------------------------------------------------------------
// picsr_pkg
// Shared types, constants and the CSR address decoder for the privileged CSR
// instruction unit.
// ----------------------------------------------------------------------------
package picsr_pkg;

  localparam int PMP_CFG_COUNT_DEF  = 16;
  localparam int PMP_ADDR_COUNT_DEF = 64;

  localparam int GEN_COUNT = 28;
  localparam int SLOT_W    = 7;

  localparam logic [63:0] VENDOR_ID     = 64'h0000_6373_6535_3336;
  localparam logic [6:0]  OP_SYSTEM     = 7'h73;
  localparam logic [11:0] FN_ECALL      = 12'h000;
  localparam logic [11:0] FN_SRET       = 12'h102;
  localparam logic [11:0] FN_MRET       = 12'h302;
  localparam logic [11:0] PMPCFG_FIRST  = 12'h3A0;
  localparam logic [11:0] PMPADDR_FIRST = 12'h3B0;

  localparam logic [2:0] F3_PRIV = 3'd0;
  localparam logic [2:0] F3_CSRW = 3'd1;
  localparam logic [2:0] F3_CSRR = 3'd2;

  localparam logic [1:0] MODE_U = 2'd0;
  localparam logic [1:0] MODE_S = 2'd1;
  localparam logic [1:0] MODE_M = 2'd2;
  localparam logic [1:0] MPP_RSVD = 2'd2;
  localparam logic [1:0] MPP_M    = 2'd3;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_IGNORED    = 2'd1;
  localparam logic [1:0] ST_KILL_RESET = 2'd2;
  localparam logic [1:0] ST_KILL_KEEP  = 2'd3;

  localparam logic [2:0] SP_SSTATUS   = 3'd0;
  localparam logic [2:0] SP_STVEC     = 3'd1;
  localparam logic [2:0] SP_SEPC      = 3'd2;
  localparam logic [2:0] SP_SCAUSE    = 3'd3;
  localparam logic [2:0] SP_MVENDORID = 3'd4;
  localparam logic [2:0] SP_MSTATUS   = 3'd5;
  localparam logic [2:0] SP_MTVEC     = 3'd6;
  localparam logic [2:0] SP_MEPC      = 3'd7;
  localparam int SP_COUNT = 8;

  localparam logic [63:0] CAUSE_ECALL_U = 64'd8;
  localparam logic [63:0] CAUSE_ECALL_S = 64'd9;

  typedef struct packed {
    logic              known;
    logic [1:0]        level;
    logic              special;
    logic [2:0]        sp;
    logic [SLOT_W-1:0] slot;
  } dec_t;

  typedef struct packed {
    logic              we;
    logic              clr;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       data;
  } commit_t;

  function automatic dec_t csr_decode(input logic [11:0] a, input int cfg_n,
                                      input int addr_n);
    dec_t        d;
    logic [11:0] off;
    d = '{known: 1'b1, level: MODE_M, special: 1'b0, sp: SP_SSTATUS, slot: '0};
    off = '0;
    case (a)
      12'h000: begin d.level = MODE_U; d.slot = 7'd0;  end
      12'h004: begin d.level = MODE_U; d.slot = 7'd1;  end
      12'h005: begin d.level = MODE_U; d.slot = 7'd2;  end
      12'h040: begin d.level = MODE_U; d.slot = 7'd3;  end
      12'h041: begin d.level = MODE_U; d.slot = 7'd4;  end
      12'h042: begin d.level = MODE_U; d.slot = 7'd5;  end
      12'h043: begin d.level = MODE_U; d.slot = 7'd6;  end
      12'h044: begin d.level = MODE_U; d.slot = 7'd7;  end
      12'h100: begin d.level = MODE_S; d.special = 1'b1; d.sp = SP_SSTATUS; end
      12'h102: begin d.level = MODE_S; d.slot = 7'd8;  end
      12'h103: begin d.level = MODE_S; d.slot = 7'd9;  end
      12'h104: begin d.level = MODE_S; d.slot = 7'd10; end
      12'h105: begin d.level = MODE_S; d.special = 1'b1; d.sp = SP_STVEC; end
      12'h106: begin d.level = MODE_S; d.slot = 7'd11; end
      12'h140: begin d.level = MODE_S; d.slot = 7'd12; end
      12'h141: begin d.level = MODE_S; d.special = 1'b1; d.sp = SP_SEPC; end
      12'h142: begin d.level = MODE_S; d.special = 1'b1; d.sp = SP_SCAUSE; end
      12'h143: begin d.level = MODE_S; d.slot = 7'd13; end
      12'h144: begin d.level = MODE_S; d.slot = 7'd14; end
      12'h180: begin d.level = MODE_S; d.slot = 7'd15; end
      12'hF11: begin d.special = 1'b1; d.sp = SP_MVENDORID; end
      12'hF12: d.slot = 7'd16;
      12'hF13: d.slot = 7'd17;
      12'hF14: d.slot = 7'd18;
      12'h300: begin d.special = 1'b1; d.sp = SP_MSTATUS; end
      12'h301: d.slot = 7'd19;
      12'h302: d.slot = 7'd20;
      12'h303: d.slot = 7'd21;
      12'h304: d.slot = 7'd22;
      12'h305: begin d.special = 1'b1; d.sp = SP_MTVEC; end
      12'h306: d.slot = 7'd23;
      12'h340: d.slot = 7'd24;
      12'h341: begin d.special = 1'b1; d.sp = SP_MEPC; end
      12'h342: d.slot = 7'd25;
      12'h343: d.slot = 7'd26;
      12'h344: d.slot = 7'd27;
      default: begin
        if (a >= PMPCFG_FIRST && 32'(a) < 32'(PMPCFG_FIRST) + 32'(cfg_n)) begin
          off    = a - PMPCFG_FIRST;
          d.slot = SLOT_W'(GEN_COUNT) + off[SLOT_W-1:0];
        end else if (a >= PMPADDR_FIRST &&
                     32'(a) < 32'(PMPADDR_FIRST) + 32'(addr_n)) begin
          off    = a - PMPADDR_FIRST;
          d.slot = SLOT_W'(GEN_COUNT + cfg_n) + off[SLOT_W-1:0];
        end else begin
          d.known = 1'b0;
        end
      end
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/picsr_store.sv =====
// ----------------------------------------------------------------------------
// picsr_store
// Memory for the general CSRs and the PMP CSRs, with per-entry valid bits so
// that a kill clears the whole bank at once, and a bypass of the write made
// in the same cycle as the read.
// ----------------------------------------------------------------------------
module picsr_store
  import picsr_pkg::*;
#(
  parameter int DEPTH = GEN_COUNT + PMP_CFG_COUNT_DEF + PMP_ADDR_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [SLOT_W-1:0] rd_slot,
  output logic [63:0]       rd_data,
  input  commit_t           cmt
);

  localparam int IDX_W = $clog2(DEPTH);

  logic [63:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [63:0]      rd_q;
  logic             rd_vld;
  logic             hit;
  logic [63:0]      hit_data;

  always_ff @(posedge clk) begin
    if (cmt.we) begin
      mem[cmt.slot[IDX_W-1:0]] <= cmt.data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_slot[IDX_W-1:0]];
      hit_data <= cmt.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
      hit    <= 1'b0;
    end else begin
      if (cmt.clr) begin
        vld <= '0;
      end else if (cmt.we) begin
        vld[cmt.slot[IDX_W-1:0]] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_slot[IDX_W-1:0]] & ~cmt.clr;
        hit    <= cmt.we && (cmt.slot == rd_slot);
      end
    end
  end

  assign rd_data = hit ? hit_data : (rd_vld ? rd_q : 64'd0);

endmodule

// ===== rtl/picsr_exec.sv =====
// ----------------------------------------------------------------------------
// picsr_exec
// Executes one instruction: privilege checks, trap entry and return, CSR
// read and write, and holds the mode and the CSRs used by trap handling.
// ----------------------------------------------------------------------------
module picsr_exec
  import picsr_pkg::*;
#(
  parameter int PMP_CFG_COUNT  = PMP_CFG_COUNT_DEF,
  parameter int PMP_ADDR_COUNT = PMP_ADDR_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        fire,
  input  logic [31:0] instruction,
  input  logic [63:0] pc,
  input  logic [63:0] src,
  input  logic [63:0] gen_data,
  output commit_t     cmt,
  output logic [63:0] next_pc,
  output logic        reg_write,
  output logic [4:0]  reg_index,
  output logic [63:0] reg_value,
  output logic [1:0]  mode_now,
  output logic [1:0]  status
);

  logic [63:0] spec      [SP_COUNT];
  logic [63:0] spec_next [SP_COUNT];
  logic [1:0]  mode;
  logic [1:0]  mode_next;

  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [4:0]  rs1;
  logic [11:0] csr;
  dec_t        dec;
  logic [63:0] val;
  logic [1:0]  mpp;
  logic        gen_we;
  logic        kill;

  assign op  = instruction[6:0];
  assign rd  = instruction[11:7];
  assign f3  = instruction[14:12];
  assign rs1 = instruction[19:15];
  assign csr = instruction[31:20];
  assign dec = csr_decode(csr, PMP_CFG_COUNT, PMP_ADDR_COUNT);
  assign val = dec.special ? spec[dec.sp] : gen_data;
  assign mpp = spec[SP_MSTATUS][12:11];

  always_comb begin
    spec_next = spec;
    mode_next = mode;
    next_pc   = pc;
    reg_write = 1'b0;
    reg_index = '0;
    reg_value = '0;
    status    = ST_DONE;
    gen_we    = 1'b0;
    if (op != OP_SYSTEM || f3 > F3_CSRR) begin
      status = ST_KILL_KEEP;
    end else if (f3 == F3_PRIV) begin
      if (rd != 5'd0 || rs1 != 5'd0) begin
        status = ST_KILL_RESET;
      end else if (csr == FN_ECALL) begin
        if (mode == MODE_U) begin
          spec_next[SP_SCAUSE] = CAUSE_ECALL_U;
          spec_next[SP_SEPC]   = pc;
          mode_next            = MODE_S;
          next_pc              = spec[SP_STVEC];
        end else if (mode == MODE_S) begin
          spec_next[SP_SCAUSE] = CAUSE_ECALL_S;
          spec_next[SP_SEPC]   = pc;
          mode_next            = MODE_M;
          next_pc              = spec[SP_MTVEC];
        end else begin
          status = ST_IGNORED;
        end
      end else if (csr == FN_SRET && mode == MODE_S) begin
        mode_next = {1'b0, spec[SP_SSTATUS][8]};
        next_pc   = spec[SP_SEPC];
      end else if (csr == FN_MRET && mode == MODE_M) begin
        if (mpp == MPP_RSVD) begin
          status = ST_KILL_KEEP;
        end else begin
          mode_next                    = (mpp == MPP_M) ? MODE_M : mpp;
          spec_next[SP_MSTATUS][12:11] = 2'b00;
          next_pc                      = spec[SP_MEPC];
        end
      end else begin
        status = ST_KILL_RESET;
      end
    end else if (f3 == F3_CSRW) begin
      if (rd != 5'd0) begin
        status = ST_KILL_RESET;
      end else if (!dec.known) begin
        status = ST_KILL_KEEP;
      end else if (mode < dec.level) begin
        status = ST_KILL_RESET;
      end else if (dec.special && dec.sp == SP_MVENDORID && src == 64'd0) begin
        status = ST_KILL_RESET;
      end else begin
        if (dec.special) begin
          spec_next[dec.sp] = src;
        end else begin
          gen_we = 1'b1;
        end
        next_pc = pc + 64'd4;
      end
    end else begin
      if (rs1 != 5'd0) begin
        status = ST_KILL_RESET;
      end else if (!dec.known) begin
        status = ST_KILL_KEEP;
      end else if (!(dec.special && dec.sp == SP_MVENDORID) && mode < dec.level) begin
        status = ST_KILL_RESET;
      end else begin
        if (rd != 5'd0) begin
          reg_write = 1'b1;
          reg_index = rd;
          reg_value = val;
        end
        next_pc = pc + 64'd4;
      end
    end
  end

  assign kill     = (status == ST_KILL_RESET);
  assign mode_now = kill ? MODE_M : mode_next;

  assign cmt.we   = fire && gen_we;
  assign cmt.clr  = fire && kill;
  assign cmt.slot = dec.slot;
  assign cmt.data = src;

  always_ff @(posedge clk) begin
    if (rst || (fire && kill)) begin
      mode <= MODE_M;
      for (int i = 0; i < SP_COUNT; i++) begin
        spec[i] <= (3'(i) == SP_MVENDORID) ? VENDOR_ID : 64'd0;
      end
    end else if (fire) begin
      mode <= mode_next;
      spec <= spec_next;
    end
  end

endmodule

// ===== rtl/privileged_csr_instruction_unit.sv =====
// ----------------------------------------------------------------------------
// privileged_csr_instruction_unit
// Emulates trapped SYSTEM instructions against a CSR bank and privilege mode.
//
//   Channel  Dir  tdata bits (lowest first)
//   s_axis   in   instruction 32, pc 64, rs1_value 64
//   m_axis   out  next_pc 64, reg_write 1, reg_index 5, reg_value 64,
//                 mode_now 2, status 2, zero pad 6
//
// One beat per cycle unless the output stalls; a beat waits in the input stage,
// then moves into the output register. The CSR memory is read as the beat is
// taken, and it executes and commits as it moves into the output register, so
// the following beat sees its writes through a bypass. Reset leaves machine
// mode and the reset CSR values in place at once. A stalled output holds only
// the output register; the input stage still takes a beat while it is empty.
// ----------------------------------------------------------------------------
module privileged_csr_instruction_unit
  import picsr_pkg::*;
#(
  parameter int PMP_CFG_COUNT  = PMP_CFG_COUNT_DEF,
  parameter int PMP_ADDR_COUNT = PMP_ADDR_COUNT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [159:0] s_tdata,  // instruction, pc, rs1_value
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [143:0] m_tdata   // next_pc, reg_write, reg_index, reg_value, mode_now, status
);

  logic        s1_valid;
  logic [31:0] s1_insn;
  logic [63:0] s1_pc;
  logic [63:0] s1_src;
  logic        advance;
  logic        accept;
  dec_t        in_dec;
  commit_t     cmt;
  logic [63:0] gen_data;
  logic [63:0] next_pc;
  logic        reg_write;
  logic [4:0]  reg_index;
  logic [63:0] reg_value;
  logic [1:0]  mode_now;
  logic [1:0]  status;

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;
  assign accept   = s_tvalid && s_tready;
  assign in_dec   = csr_decode(s_tdata[31:20], PMP_CFG_COUNT, PMP_ADDR_COUNT);

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_insn <= s_tdata[31:0];
      s1_pc   <= s_tdata[95:32];
      s1_src  <= (s_tdata[19:15] == 5'd0) ? 64'd0 : s_tdata[159:96];
    end
    if (advance) begin
      m_tdata <= {6'd0, status, mode_now, reg_value, reg_index, reg_write, next_pc};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  picsr_store #(
    .DEPTH(GEN_COUNT + PMP_CFG_COUNT + PMP_ADDR_COUNT)
  ) u_store (
    .clk    (clk),
    .rst    (rst),
    .rd_en  (accept),
    .rd_slot(in_dec.slot),
    .rd_data(gen_data),
    .cmt    (cmt)
  );

  picsr_exec #(
    .PMP_CFG_COUNT (PMP_CFG_COUNT),
    .PMP_ADDR_COUNT(PMP_ADDR_COUNT)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .fire       (advance),
    .instruction(s1_insn),
    .pc         (s1_pc),
    .src        (s1_src),
    .gen_data   (gen_data),
    .cmt        (cmt),
    .next_pc    (next_pc),
    .reg_write  (reg_write),
    .reg_index  (reg_index),
    .reg_value  (reg_value),
    .mode_now   (mode_now),
    .status     (status)
  );

endmodule

// ===== rtl/picsr_chk.sv =====
// ----------------------------------------------------------------------------
// picsr_chk
// Port-level checks on the result stream of the CSR instruction unit.
// ----------------------------------------------------------------------------
module picsr_chk
  import picsr_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [143:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_kill_mode: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[137:136] == ST_KILL_RESET |-> m_tdata[135:134] == MODE_M)
    else $error("kill did not return to machine mode");

  a_wb_only_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[64] |-> m_tdata[137:136] == ST_DONE && m_tdata[69:65] != 5'd0)
    else $error("write-back on a failed step or to x0");

  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    m_tready |-> s_tready)
    else $error("input not ready while the output drains");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid straight after reset");

endmodule

bind privileged_csr_instruction_unit picsr_chk u_picsr_chk (
  .clk     (clk),
  .rst     (rst),
  .s_tready(s_tready),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata (m_tdata)
);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the privileged CSR instruction unit. A table of directed beats is
// followed by random beats that are mostly legal SYSTEM instructions. Every
// beat runs through a predictor that keeps its own CSR bank and privilege
// mode, and each output beat is compared field by field with the oldest
// expected result. Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb;
  import picsr_pkg::*;

  typedef struct packed {
    logic [63:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [63:0] reg_value;
    logic [1:0]  mode_now;
    logic [1:0]  status;
  } outcome_t;

  typedef struct {
    logic [31:0] insn;
    logic [63:0] pc;
    logic [63:0] rs1v;
    logic        typed;
    outcome_t    want;
  } row_t;

  localparam int LIMIT = 400000;
  localparam int N_RANDOM = 1750;

  logic          clk;
  logic          rst;
  logic          s_tvalid;
  logic          s_tready;
  logic [159:0]  s_tdata;
  logic          m_tvalid;
  logic          m_tready;
  logic [143:0]  m_tdata;

  privileged_csr_instruction_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  logic [11:0] csr_map [36] = '{
    12'h000, 12'h004, 12'h005, 12'h040, 12'h041, 12'h042, 12'h043, 12'h044,
    12'h100, 12'h102, 12'h103, 12'h104, 12'h105, 12'h106, 12'h140, 12'h141,
    12'h142, 12'h143, 12'h144, 12'h180,
    12'hF11, 12'hF12, 12'hF13, 12'hF14, 12'h300, 12'h301, 12'h302, 12'h303,
    12'h304, 12'h305, 12'h306, 12'h340, 12'h341, 12'h342, 12'h343, 12'h344
  };
  localparam int K_SSTATUS = 8, K_STVEC = 12, K_SEPC = 15, K_SCAUSE = 16;
  localparam int K_VENDOR = 20, K_MSTATUS = 24, K_MTVEC = 29, K_MEPC = 32;

  logic [63:0] csr_model [36];
  logic [63:0] pmpcfg_model [16];
  logic [63:0] pmpaddr_model [64];
  logic [1:0]  mode_model;

  outcome_t    expected_q[$];
  row_t        beats_q[$];
  int          errors = 0;
  int          cycle = 0;
  bit          calm = 1'b0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, exp, cycle);
    errors++;
  endtask

  function automatic void clear_model();
    foreach (csr_model[i]) csr_model[i] = '0;
    foreach (pmpcfg_model[i]) pmpcfg_model[i] = '0;
    foreach (pmpaddr_model[i]) pmpaddr_model[i] = '0;
    csr_model[K_VENDOR] = VENDOR_ID;
    mode_model = MODE_M;
  endfunction

  // kind: 0 unknown, 1 bank, 2 pmp config, 3 pmp address
  function automatic void locate(input logic [11:0] a, output int kind, output int idx,
                                 output logic [1:0] lvl);
    kind = 0; idx = 0; lvl = MODE_M;
    for (int i = 0; i < 36; i++)
      if (csr_map[i] == a) begin
        kind = 1; idx = i; lvl = (i < 8) ? MODE_U : (i < 20) ? MODE_S : MODE_M;
      end
    if (kind == 0 && a >= PMPCFG_FIRST && a < PMPCFG_FIRST + 16) begin
      kind = 2; idx = int'(a - PMPCFG_FIRST);
    end else if (kind == 0 && a >= PMPADDR_FIRST && a < PMPADDR_FIRST + 64) begin
      kind = 3; idx = int'(a - PMPADDR_FIRST);
    end
  endfunction

  function automatic outcome_t execute(input logic [31:0] insn, input logic [63:0] pc,
                                       input logic [63:0] rv);
    outcome_t    o;
    logic [4:0]  rd, rs1;
    logic [2:0]  f3;
    logic [11:0] a;
    logic [63:0] src, cur;
    logic [1:0]  mpp, lvl;
    int          kind, idx;
    rd = insn[11:7]; f3 = insn[14:12]; rs1 = insn[19:15]; a = insn[31:20];
    src = (rs1 == 5'd0) ? 64'd0 : rv;
    o = '0;
    o.next_pc = pc;
    o.status = ST_DONE;
    if (insn[6:0] != OP_SYSTEM || f3 > F3_CSRR) begin
      o.status = ST_KILL_KEEP;
    end else if (f3 == F3_PRIV) begin
      if (rd != 5'd0 || rs1 != 5'd0) o.status = ST_KILL_RESET;
      else if (a == FN_ECALL) begin
        if (mode_model == MODE_U) begin
          csr_model[K_SCAUSE] = CAUSE_ECALL_U; csr_model[K_SEPC] = pc;
          mode_model = MODE_S; o.next_pc = csr_model[K_STVEC];
        end else if (mode_model == MODE_S) begin
          csr_model[K_SCAUSE] = CAUSE_ECALL_S; csr_model[K_SEPC] = pc;
          mode_model = MODE_M; o.next_pc = csr_model[K_MTVEC];
        end else o.status = ST_IGNORED;
      end else if (a == FN_SRET && mode_model == MODE_S) begin
        mode_model = {1'b0, csr_model[K_SSTATUS][8]};
        o.next_pc = csr_model[K_SEPC];
      end else if (a == FN_MRET && mode_model == MODE_M) begin
        mpp = csr_model[K_MSTATUS][12:11];
        if (mpp == MPP_RSVD) o.status = ST_KILL_KEEP;
        else begin
          mode_model = (mpp == MPP_M) ? MODE_M : mpp;
          csr_model[K_MSTATUS][12:11] = 2'b00;
          o.next_pc = csr_model[K_MEPC];
        end
      end else o.status = ST_KILL_RESET;
    end else begin
      locate(a, kind, idx, lvl);
      if ((f3 == F3_CSRW) ? (rd != 5'd0) : (rs1 != 5'd0)) o.status = ST_KILL_RESET;
      else if (kind == 0) o.status = ST_KILL_KEEP;
      else if (f3 == F3_CSRW) begin
        if (mode_model < lvl) o.status = ST_KILL_RESET;
        else if (kind == 1 && idx == K_VENDOR && src == 64'd0) o.status = ST_KILL_RESET;
        else begin
          case (kind)
            1: csr_model[idx] = src;
            2: pmpcfg_model[idx] = src;
            default: pmpaddr_model[idx] = src;
          endcase
          o.next_pc = pc + 64'd4;
        end
      end else begin
        if (!(kind == 1 && idx == K_VENDOR) && mode_model < lvl) o.status = ST_KILL_RESET;
        else begin
          cur = (kind == 1) ? csr_model[idx] : (kind == 2) ? pmpcfg_model[idx]
                                                           : pmpaddr_model[idx];
          if (rd != 5'd0) begin
            o.reg_write = 1'b1; o.reg_index = rd; o.reg_value = cur;
          end
          o.next_pc = pc + 64'd4;
        end
      end
    end
    if (o.status == ST_KILL_RESET) clear_model();
    o.mode_now = mode_model;
    return o;
  endfunction

  function automatic logic [31:0] encode(input logic [11:0] a, input logic [4:0] rs1,
                                         input logic [2:0] f3, input logic [4:0] rd);
    return {a, rs1, f3, rd, OP_SYSTEM};
  endfunction

  function automatic logic [63:0] rnd64();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = '0;
      1: v = '1;
      2: v = v & 64'h1F00;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [11:0] pick_csr();
    case ($urandom_range(0, 9))
      0: return PMPCFG_FIRST + 12'($urandom_range(0, 16));
      1: return PMPADDR_FIRST + 12'($urandom_range(0, 64));
      2: return 12'($urandom);
      default: return csr_map[$urandom_range(0, 35)];
    endcase
  endfunction

  function automatic row_t random_row();
    row_t r;
    logic [4:0] reg_n;
    r.typed = 1'b0;
    r.pc = rnd64();
    r.rs1v = rnd64();
    r.want = '0;
    reg_n = ($urandom_range(0, 4) == 0) ? 5'd0 : 5'($urandom_range(1, 31));
    case ($urandom_range(0, 19))
      0: r.insn = $urandom;
      1: r.insn = encode(pick_csr(), 5'($urandom), 3'($urandom_range(3, 7)), 5'($urandom));
      2: r.insn = encode(12'($urandom), 5'($urandom), F3_PRIV, 5'($urandom));
      3: r.insn = encode(pick_csr(), 5'($urandom_range(1, 31)), F3_CSRR, 5'($urandom));
      4: r.insn = encode(FN_ECALL, 5'd0, F3_PRIV, 5'd0);
      5: r.insn = encode(FN_SRET, 5'd0, F3_PRIV, 5'd0);
      6: r.insn = encode(FN_MRET, 5'd0, F3_PRIV, 5'd0);
      7, 8, 9, 10, 11: r.insn = encode(pick_csr(), reg_n, F3_CSRW,
                                       ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'd0);
      default: r.insn = encode(pick_csr(), 5'd0, F3_CSRR, reg_n);
    endcase
    return r;
  endfunction

  function automatic row_t fixed(input logic [31:0] insn, input logic [63:0] pc,
                                 input logic [63:0] rv);
    row_t r;
    r.insn = insn; r.pc = pc; r.rs1v = rv; r.typed = 1'b0; r.want = '0;
    return r;
  endfunction

  function automatic row_t typed_row(input logic [31:0] insn, input logic [63:0] pc,
                                     input logic [63:0] rv, input outcome_t w);
    row_t r;
    r = fixed(insn, pc, rv);
    r.typed = 1'b1; r.want = w;
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) cycle <= cycle + 1;

  initial begin
    row_t     rw;
    outcome_t pred;
    logic [63:0] far;
    far = 64'hFFFF_FFFF_FFFF_FFFC;
    rst = 1; s_tvalid = 0; s_tdata = '0;
    clear_model();
    beats_q.push_back(typed_row(encode(12'hF11, 5'd0, F3_CSRR, 5'd31), far, '1,
                      '{64'd0, 1'b1, 5'd31, VENDOR_ID, MODE_M, ST_DONE}));
    beats_q.push_back(typed_row(encode(FN_ECALL, 5'd0, F3_PRIV, 5'd0), 64'h100, 64'd0,
                      '{64'h100, 1'b0, 5'd0, 64'd0, MODE_M, ST_IGNORED}));
    beats_q.push_back(typed_row(32'hFFFF_FFFF, 64'h0, 64'd0,
                      '{64'h0, 1'b0, 5'd0, 64'd0, MODE_M, ST_KILL_KEEP}));
    beats_q.push_back(typed_row(encode(12'h300, 5'd0, 3'd5, 5'd0), 64'h8, 64'd0,
                      '{64'h8, 1'b0, 5'd0, 64'd0, MODE_M, ST_KILL_KEEP}));
    beats_q.push_back(typed_row(encode(12'h7FF, 5'd0, F3_CSRR, 5'd1), 64'h8, 64'd0,
                      '{64'h8, 1'b0, 5'd0, 64'd0, MODE_M, ST_KILL_KEEP}));
    beats_q.push_back(typed_row(encode(FN_ECALL, 5'd3, F3_PRIV, 5'd0), 64'h8, 64'd0,
                      '{64'h8, 1'b0, 5'd0, 64'd0, MODE_M, ST_KILL_RESET}));
    beats_q.push_back(typed_row(encode(12'hF11, 5'd1, F3_CSRW, 5'd0), 64'h8, '1,
                      '{64'hC, 1'b0, 5'd0, 64'd0, MODE_M, ST_DONE}));
    beats_q.push_back(fixed(encode(12'hF11, 5'd0, F3_CSRW, 5'd0), 64'h8, '1));
    beats_q.push_back(fixed(encode(12'h305, 5'd2, F3_CSRW, 5'd0), 64'd0, 64'h8000_0000));
    beats_q.push_back(fixed(encode(12'h105, 5'd2, F3_CSRW, 5'd0), 64'd0, far));
    beats_q.push_back(fixed(encode(12'h341, 5'd2, F3_CSRW, 5'd0), 64'd0, 64'h4000));
    beats_q.push_back(fixed(encode(12'h300, 5'd2, F3_CSRW, 5'd0), 64'd0, 64'h0));
    beats_q.push_back(fixed(encode(FN_MRET, 5'd0, F3_PRIV, 5'd0), far, 64'd0));
    beats_q.push_back(fixed(encode(12'h300, 5'd0, F3_CSRR, 5'd4), 64'd0, 64'd0));
    beats_q.push_back(fixed(encode(FN_ECALL, 5'd0, F3_PRIV, 5'd0), 64'h1234, 64'd0));
    beats_q.push_back(fixed(encode(12'h100, 5'd2, F3_CSRW, 5'd0), 64'd0, 64'h100));
    beats_q.push_back(fixed(encode(FN_SRET, 5'd0, F3_PRIV, 5'd0), 64'd0, 64'd0));
    beats_q.push_back(fixed(encode(FN_ECALL, 5'd0, F3_PRIV, 5'd0), 64'h2000, 64'd0));
    beats_q.push_back(fixed(encode(12'h142, 5'd0, F3_CSRR, 5'd5), 64'd0, 64'd0));
    beats_q.push_back(fixed(encode(12'h300, 5'd2, F3_CSRW, 5'd0), 64'd0, 64'h1000));
    beats_q.push_back(fixed(encode(FN_MRET, 5'd0, F3_PRIV, 5'd0), 64'd0, 64'd0));
    beats_q.push_back(fixed(encode(12'h300, 5'd0, F3_CSRR, 5'd0), 64'd0, 64'd0));
    beats_q.push_back(fixed(encode(12'h3EF, 5'd2, F3_CSRW, 5'd0), 64'd0, '1));
    beats_q.push_back(fixed(encode(12'h3EF, 5'd0, F3_CSRR, 5'd9), 64'd0, 64'd0));
    beats_q.push_back(fixed(encode(12'h3F0, 5'd0, F3_CSRR, 5'd9), 64'd0, 64'd0));
    repeat (11) @(posedge clk);
    rst <= 0;
    for (int n = 0; n < N_RANDOM; n++) beats_q.push_back(random_row());
    while (beats_q.size() > 0) begin
      rw = beats_q.pop_front();
      pred = execute(rw.insn, rw.pc, rw.rs1v);
      if (rw.typed && pred !== rw.want)
        report("table row status", 64'(pred.status), 64'(rw.want.status));
      expected_q.push_back(pred);
      while (!calm && $urandom_range(0, 99) < 35) begin
        s_tvalid <= 0;
        @(posedge clk);
      end
      s_tvalid <= 1;
      s_tdata <= {rw.rs1v, rw.pc, rw.insn};
      @(posedge clk);
      while (!s_tready) @(posedge clk);
    end
    s_tvalid <= 0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    m_tready = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      calm <= (cycle > 800 && cycle < 1400);
      m_tready <= calm || ($urandom_range(0, 99) >= 35);
    end
  end

  always @(posedge clk) begin
    outcome_t got, exp;
    if (!rst && m_tvalid && m_tready) begin
      got.next_pc   = m_tdata[63:0];
      got.reg_write = m_tdata[64];
      got.reg_index = m_tdata[69:65];
      got.reg_value = m_tdata[133:70];
      got.mode_now  = m_tdata[135:134];
      got.status    = m_tdata[137:136];
      if (expected_q.size() == 0) begin
        report("unexpected beat", got.next_pc, 64'd0);
      end else begin
        exp = expected_q.pop_front();
        if (got.next_pc !== exp.next_pc) report("next_pc", got.next_pc, exp.next_pc);
        if (got.reg_write !== exp.reg_write)
          report("reg_write", 64'(got.reg_write), 64'(exp.reg_write));
        if (got.reg_index !== exp.reg_index)
          report("reg_index", 64'(got.reg_index), 64'(exp.reg_index));
        if (got.reg_value !== exp.reg_value) report("reg_value", got.reg_value, exp.reg_value);
        if (got.mode_now !== exp.mode_now)
          report("mode_now", 64'(got.mode_now), 64'(exp.mode_now));
        if (got.status !== exp.status) report("status", 64'(got.status), 64'(exp.status));
      end
    end
    if (cycle > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end
endmodule
